FILE: rtl/trilateration_three_anchors_core_assert.svh
// Assertion macros for the trilateration core.
`ifndef TRILATERATION_THREE_ANCHORS_CORE_ASSERT_SVH
`define TRILATERATION_THREE_ANCHORS_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define TRILAT_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TRILAT_ASSERT_RST(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: rtl/trilat_pkg.sv
`timescale 1ns / 1ps

package trilat_pkg;

  localparam int TolWidth = 8;
  localparam logic [TolWidth-1:0] TolReset = 8'd3;

  typedef struct packed {
    logic valid;
    logic ok;
  } trilat_ctl_t;

endpackage

FILE: rtl/trilat_ifs.sv
`timescale 1ns / 1ps

interface trilat_anchor_if #(parameter int COORD_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] anchor_a_x;
  logic signed [COORD_WIDTH-1:0] anchor_a_y;
  logic [COORD_WIDTH-2:0] anchor_a_range;
  logic signed [COORD_WIDTH-1:0] anchor_b_x;
  logic signed [COORD_WIDTH-1:0] anchor_b_y;
  logic [COORD_WIDTH-2:0] anchor_b_range;
  logic signed [COORD_WIDTH-1:0] anchor_c_x;
  logic signed [COORD_WIDTH-1:0] anchor_c_y;
  logic [COORD_WIDTH-2:0] anchor_c_range;

  modport source (
    output valid, anchor_a_x, anchor_a_y, anchor_a_range, anchor_b_x, anchor_b_y,
    anchor_b_range, anchor_c_x, anchor_c_y, anchor_c_range,
    input ready
  );
  modport sink (
    input valid, anchor_a_x, anchor_a_y, anchor_a_range, anchor_b_x, anchor_b_y,
    anchor_b_range, anchor_c_x, anchor_c_y, anchor_c_range,
    output ready
  );
endinterface

interface trilat_fix_if #(parameter int COORD_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic fix_valid;

  modport source (output valid, pos_x, pos_y, fix_valid, input ready);
  modport sink (input valid, pos_x, pos_y, fix_valid, output ready);
endinterface

FILE: rtl/trilat_div.sv
`timescale 1ns / 1ps

module trilat_div #(
  parameter int QW = 24,
  parameter int NW = 76,
  parameter int DENW = 52
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  trilat_pkg::trilat_ctl_t ctl_in,
  input  logic signed [NW-1:0] num [2],
  input  logic signed [DENW-1:0] den,
  output trilat_pkg::trilat_ctl_t ctl_out,
  output logic signed [QW-1:0] quot [2]
);
  import trilat_pkg::*;

  localparam int NST = NW + 1;

  trilat_ctl_t ctl_st [NST];
  logic [DENW-1:0] dv_st [NST];
  logic neg_st [NST][2];
  logic [NW-1:0] nm_st [NST][2];
  logic [DENW-1:0] rm_st [NST][2];
  logic [QW-1:0] qt_st [NST][2];
  logic ovf_st [NST][2];

  logic [DENW-1:0] dv_next [NST];
  logic neg_next [NST][2];
  logic [NW-1:0] nm_next [NST][2];
  logic [DENW-1:0] rm_next [NST][2];
  logic [QW-1:0] qt_next [NST][2];
  logic ovf_next [NST][2];
  logic signed [QW-1:0] quot_next [2];

  // Stage zero takes magnitudes; each later stage retires one quotient bit.
  always_comb begin
    logic [DENW:0] rs;
    logic [DENW:0] rd;
    logic ge;
    dv_next[0] = den[DENW-1] ? DENW'(-den) : DENW'(den);
    for (int l = 0; l < 2; l++) begin
      neg_next[0][l] = num[l][NW-1] ^ den[DENW-1];
      nm_next[0][l] = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
      rm_next[0][l] = '0;
      qt_next[0][l] = '0;
      ovf_next[0][l] = 1'b0;
    end
    for (int i = 0; i < NW; i++) begin
      dv_next[i+1] = dv_st[i];
      for (int l = 0; l < 2; l++) begin
        rs = {rm_st[i][l], nm_st[i][l][NW-1]};
        rd = rs - {1'b0, dv_st[i]};
        ge = rs >= {1'b0, dv_st[i]};
        neg_next[i+1][l] = neg_st[i][l];
        nm_next[i+1][l] = {nm_st[i][l][NW-2:0], 1'b0};
        rm_next[i+1][l] = ge ? rd[DENW-1:0] : rs[DENW-1:0];
        qt_next[i+1][l] = {qt_st[i][l][QW-2:0], ge};
        ovf_next[i+1][l] = ovf_st[i][l] | qt_st[i][l][QW-1];
      end
    end
  end

  // Round half away from zero, clamp to the signed range; zero when not ok.
  always_comb begin
    logic rnd;
    logic [QW:0] qr;
    logic [QW:0] lim;
    logic [QW:0] qs;
    logic [QW:0] res;
    for (int l = 0; l < 2; l++) begin
      rnd = {rm_st[NW][l], 1'b0} >= {1'b0, dv_st[NW]};
      qr = {1'b0, qt_st[NW][l]} + (QW+1)'(rnd);
      lim = ((QW+1)'(1) << (QW - 1)) - (QW+1)'(!neg_st[NW][l]);
      qs = (ovf_st[NW][l] || qr > lim) ? lim : qr;
      res = neg_st[NW][l] ? -qs : qs;
      quot_next[l] = ctl_st[NW].ok ? res[QW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) begin
        ctl_st[i] <= '0;
      end
      ctl_out <= '0;
    end else if (en) begin
      ctl_st[0] <= ctl_in;
      for (int i = 1; i < NST; i++) begin
        ctl_st[i] <= ctl_st[i-1];
      end
      ctl_out <= ctl_st[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        dv_st[i] <= dv_next[i];
        for (int l = 0; l < 2; l++) begin
          neg_st[i][l] <= neg_next[i][l];
          nm_st[i][l] <= nm_next[i][l];
          rm_st[i][l] <= rm_next[i][l];
          qt_st[i][l] <= qt_next[i][l];
          ovf_st[i][l] <= ovf_next[i][l];
        end
      end
      quot[0] <= quot_next[0];
      quot[1] <= quot_next[1];
    end
  end

endmodule

FILE: rtl/trilateration_three_anchors_core.sv
`timescale 1ns / 1ps
// Channel   Role    Payload
// anchors   sink    three anchors: x, y and horizontal range each
// fix       source  pos_x, pos_y, fix_valid
// cfg       write   equal_tolerance, 8 bits, no read-back
//
// One request is accepted per cycle while the output buffer is not full.
// The restoring divider sets most of the latency from acceptance to a valid
// result; it spends one pipeline stage per quotient bit.
// The whole pipeline advances together; it holds only when both entries of the
// two-entry output buffer are occupied. Reset is synchronous and empties it.

module trilateration_three_anchors_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  trilat_anchor_if.sink anchors,
  trilat_fix_if.source fix
);
  import trilat_pkg::*;

  `include "trilateration_three_anchors_core_assert.svh"

  localparam int W = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int SW = 2 * W;
  localparam int RSW = 2 * W - 2;
  localparam int RW = 2 * W + 2;
  localparam int PW = 2 * W + 2;
  localparam int DETW = 2 * W + 3;
  localparam int HW = 2 * W + 2;
  localparam int LW = 2 * W + 3;
  localparam int NW = 3 * W + 4;
  localparam int DENW = 2 * W + 4;

  logic [TolWidth-1:0] equal_tolerance;
  logic en;
  logic [7:1] vld;

  logic signed [W-1:0] s1_x [3];
  logic signed [W-1:0] s1_y [3];
  logic [W-2:0] s1_r [3];

  logic signed [W-1:0] s2_x [3];
  logic signed [W-1:0] s2_y [3];
  logic [W-2:0] s2_r [3];
  logic s2_eq01, s2_eq12, s2_eq02;
  logic s2_eq01_next, s2_eq12_next, s2_eq02_next;

  logic signed [W-1:0] s3_x [3];
  logic signed [W-1:0] s3_y [3];
  logic [W-2:0] s3_r [3];
  logic signed [DW-1:0] s3_dx1, s3_dy1, s3_dx2, s3_dy2;
  logic s3_bad;
  logic [1:0] o0, o1, o2;
  logic signed [DW-1:0] dx1_next, dy1_next, dx2_next, dy2_next;
  logic bad3_next;

  logic signed [SW-1:0] s4_sqx [3];
  logic signed [SW-1:0] s4_sqy [3];
  logic [RSW-1:0] s4_sqr [3];
  logic signed [PW-1:0] s4_p1, s4_p2;
  logic signed [DW-1:0] s4_dx1, s4_dy1, s4_dx2, s4_dy2;
  logic s4_bad;

  logic signed [RW-1:0] s5_n1, s5_n2;
  logic signed [DETW-1:0] s5_det;
  logic signed [DW-1:0] s5_dx1, s5_dy1, s5_dx2, s5_dy2;
  logic s5_bad;
  logic signed [RW-1:0] n1_next, n2_next;
  logic signed [DETW-1:0] det_next;

  logic signed [W+1:0] n1_lo, n2_lo;
  logic signed [W:0] n1_hi, n2_hi;
  logic signed [HW-1:0] s6_ah, s6_bh, s6_ch, s6_dh;
  logic signed [LW-1:0] s6_al, s6_bl, s6_cl, s6_dl;
  logic signed [DETW-1:0] s6_det;
  logic s6_bad;

  logic signed [NW-1:0] s7_num [2];
  logic signed [DENW-1:0] s7_den;
  logic s7_ok;

  trilat_ctl_t div_ctl_in, div_ctl_out;
  logic signed [W-1:0] div_quot [2];

  logic [1:0] count;
  logic push, pop;
  logic signed [W-1:0] e0_x, e0_y, e1_x, e1_y;
  logic e0_v, e1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      equal_tolerance <= TolReset;
    end else if (cfg_wr_en) begin
      equal_tolerance <= cfg_wr_data;
    end
  end

  assign en = count != 2'd2;
  assign anchors.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], anchors.valid};
    end
  end

  // Closeness of the x coordinates.
  always_comb begin
    logic signed [DW-1:0] d01, d12, d02;
    logic [DW-1:0] m01, m12, m02;
    d01 = DW'(s1_x[0]) - DW'(s1_x[1]);
    d12 = DW'(s1_x[1]) - DW'(s1_x[2]);
    d02 = DW'(s1_x[0]) - DW'(s1_x[2]);
    m01 = d01[DW-1] ? DW'(-d01) : DW'(d01);
    m12 = d12[DW-1] ? DW'(-d12) : DW'(d12);
    m02 = d02[DW-1] ? DW'(-d02) : DW'(d02);
    s2_eq01_next = m01 < DW'(equal_tolerance);
    s2_eq12_next = m12 < DW'(equal_tolerance);
    s2_eq02_next = m02 < DW'(equal_tolerance);
  end

  // Reorder so that the reference anchor differs in x from the other two.
  always_comb begin
    priority if (s2_eq01) begin
      o0 = 2'd2; o1 = 2'd1; o2 = 2'd0;
    end else if (s2_eq02) begin
      o0 = 2'd1; o1 = 2'd0; o2 = 2'd2;
    end else begin
      o0 = 2'd0; o1 = 2'd1; o2 = 2'd2;
    end
    dx1_next = DW'(s2_x[o0]) - DW'(s2_x[o1]);
    dy1_next = DW'(s2_y[o0]) - DW'(s2_y[o1]);
    dx2_next = DW'(s2_x[o0]) - DW'(s2_x[o2]);
    dy2_next = DW'(s2_y[o0]) - DW'(s2_y[o2]);
    bad3_next = (s2_eq01 && s2_eq12) || dx1_next == '0 || dx2_next == '0;
  end

  always_comb begin
    n1_next = RW'(s4_sqx[0]) - RW'(s4_sqx[1]) + RW'(s4_sqy[0]) - RW'(s4_sqy[1])
            + RW'(s4_sqr[1]) - RW'(s4_sqr[0]);
    n2_next = RW'(s4_sqx[0]) - RW'(s4_sqx[2]) + RW'(s4_sqy[0]) - RW'(s4_sqy[2])
            + RW'(s4_sqr[2]) - RW'(s4_sqr[0]);
    det_next = DETW'(s4_p1) - DETW'(s4_p2);
  end

  // The right-hand sides are split in two halves to keep each product narrow.
  assign n1_lo = {1'b0, s5_n1[W:0]};
  assign n2_lo = {1'b0, s5_n2[W:0]};
  assign n1_hi = s5_n1[RW-1:W+1];
  assign n2_hi = s5_n2[RW-1:W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x[0] <= anchors.anchor_a_x;
      s1_y[0] <= anchors.anchor_a_y;
      s1_r[0] <= anchors.anchor_a_range;
      s1_x[1] <= anchors.anchor_b_x;
      s1_y[1] <= anchors.anchor_b_y;
      s1_r[1] <= anchors.anchor_b_range;
      s1_x[2] <= anchors.anchor_c_x;
      s1_y[2] <= anchors.anchor_c_y;
      s1_r[2] <= anchors.anchor_c_range;

      s2_x <= s1_x;
      s2_y <= s1_y;
      s2_r <= s1_r;
      s2_eq01 <= s2_eq01_next;
      s2_eq12 <= s2_eq12_next;
      s2_eq02 <= s2_eq02_next;

      s3_x[0] <= s2_x[o0];
      s3_x[1] <= s2_x[o1];
      s3_x[2] <= s2_x[o2];
      s3_y[0] <= s2_y[o0];
      s3_y[1] <= s2_y[o1];
      s3_y[2] <= s2_y[o2];
      s3_r[0] <= s2_r[o0];
      s3_r[1] <= s2_r[o1];
      s3_r[2] <= s2_r[o2];
      s3_dx1 <= dx1_next;
      s3_dy1 <= dy1_next;
      s3_dx2 <= dx2_next;
      s3_dy2 <= dy2_next;
      s3_bad <= bad3_next;

      for (int k = 0; k < 3; k++) begin
        s4_sqx[k] <= SW'(s3_x[k]) * SW'(s3_x[k]);
        s4_sqy[k] <= SW'(s3_y[k]) * SW'(s3_y[k]);
        s4_sqr[k] <= RSW'(s3_r[k]) * RSW'(s3_r[k]);
      end
      s4_p1 <= PW'(s3_dx1) * PW'(s3_dy2);
      s4_p2 <= PW'(s3_dx2) * PW'(s3_dy1);
      s4_dx1 <= s3_dx1;
      s4_dy1 <= s3_dy1;
      s4_dx2 <= s3_dx2;
      s4_dy2 <= s3_dy2;
      s4_bad <= s3_bad;

      s5_n1 <= n1_next;
      s5_n2 <= n2_next;
      s5_det <= det_next;
      s5_dx1 <= s4_dx1;
      s5_dy1 <= s4_dy1;
      s5_dx2 <= s4_dx2;
      s5_dy2 <= s4_dy2;
      s5_bad <= s4_bad;

      s6_ah <= HW'(n1_hi) * HW'(s5_dy2);
      s6_al <= LW'(n1_lo) * LW'(s5_dy2);
      s6_bh <= HW'(n2_hi) * HW'(s5_dy1);
      s6_bl <= LW'(n2_lo) * LW'(s5_dy1);
      s6_ch <= HW'(n2_hi) * HW'(s5_dx1);
      s6_cl <= LW'(n2_lo) * LW'(s5_dx1);
      s6_dh <= HW'(n1_hi) * HW'(s5_dx2);
      s6_dl <= LW'(n1_lo) * LW'(s5_dx2);
      s6_det <= s5_det;
      s6_bad <= s5_bad || s5_det == '0;

      s7_num[0] <= (NW'(s6_ah) <<< (W + 1)) + NW'(s6_al)
                 - (NW'(s6_bh) <<< (W + 1)) - NW'(s6_bl);
      s7_num[1] <= (NW'(s6_ch) <<< (W + 1)) + NW'(s6_cl)
                 - (NW'(s6_dh) <<< (W + 1)) - NW'(s6_dl);
      s7_den <= {s6_det, 1'b0};
      s7_ok <= !s6_bad;
    end
  end

  assign div_ctl_in.valid = vld[7];
  assign div_ctl_in.ok = s7_ok;

  trilat_div #(
    .QW(W),
    .NW(NW),
    .DENW(DENW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .ctl_in(div_ctl_in),
    .num(s7_num),
    .den(s7_den),
    .ctl_out(div_ctl_out),
    .quot(div_quot)
  );

  // Two-entry output buffer; entry zero drives the result channel.
  assign push = div_ctl_out.valid && en;
  assign pop = fix.valid && fix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count - 2'(pop)) == 2'd0) begin
      e0_x <= div_quot[0];
      e0_y <= div_quot[1];
      e0_v <= div_ctl_out.ok;
    end else if (pop) begin
      e0_x <= e1_x;
      e0_y <= e1_y;
      e0_v <= e1_v;
    end
    if (push && (count - 2'(pop)) != 2'd0) begin
      e1_x <= div_quot[0];
      e1_y <= div_quot[1];
      e1_v <= div_ctl_out.ok;
    end
  end

  assign fix.valid = count != 2'd0;
  assign fix.pos_x = e0_x;
  assign fix.pos_y = e0_y;
  assign fix.fix_valid = e0_v;

  `TRILAT_ASSERT_RST(a_reset_empty, clk, rst |=> (count == 2'd0 && vld == '0),
    "Pipeline not empty after reset")
  `TRILAT_ASSERT(a_buffer_bound, clk, rst, count != 2'd3, "Output buffer overflow")
  `TRILAT_ASSERT(a_stall_holds, clk, rst, !en |=> $stable(vld),
    "Pipeline moved while stalled")
  `TRILAT_ASSERT(a_invalid_zero, clk, rst,
    fix.valid && !fix.fix_valid |-> fix.pos_x == '0 && fix.pos_y == '0,
    "Invalid fix carries a nonzero position")

endmodule
